>>> hdl/ibm_pkg.sv
package ibm_pkg;

    // line positions within one bus
    localparam logic [1:0] POS_SCL = 2'd0;
    localparam logic [1:0] POS_SDA = 2'd1;
    localparam logic [1:0] POS_DRV = 2'd2;

    // sequencer phases
    localparam logic [3:0] PH_IDLE    = 4'd0;
    localparam logic [3:0] PH_ST_A    = 4'd1;
    localparam logic [3:0] PH_ST_B    = 4'd2;
    localparam logic [3:0] PH_SP_A    = 4'd3;
    localparam logic [3:0] PH_SP_B    = 4'd4;
    localparam logic [3:0] PH_SP_C    = 4'd5;
    localparam logic [3:0] PH_W_BIT   = 4'd6;
    localparam logic [3:0] PH_W_HIGH  = 4'd7;
    localparam logic [3:0] PH_W_LOW   = 4'd8;
    localparam logic [3:0] PH_A_REL   = 4'd9;
    localparam logic [3:0] PH_A_HIGH  = 4'd10;
    localparam logic [3:0] PH_A_POLL  = 4'd11;
    localparam logic [3:0] PH_R_HIGH  = 4'd12;
    localparam logic [3:0] PH_R_LOW   = 4'd13;
    localparam logic [3:0] PH_RA_HIGH = 4'd14;
    localparam logic [3:0] PH_RA_END  = 4'd15;

    // command codes
    localparam logic [2:0] FN_NONE  = 3'd0;
    localparam logic [2:0] FN_START = 3'd1;
    localparam logic [2:0] FN_STOP  = 3'd2;
    localparam logic [2:0] FN_WRITE = 3'd3;
    localparam logic [2:0] FN_READ  = 3'd4;

    // configuration register indexes
    localparam logic [2:0] CFG_START_STOP_DELAY = 3'd0;
    localparam logic [2:0] CFG_BIT_DELAY        = 3'd1;
    localparam logic [2:0] CFG_ACK_HIGH_DELAY   = 3'd2;
    localparam logic [2:0] CFG_SETTLE_DELAY     = 3'd3;
    localparam logic [2:0] CFG_ACK_TIMEOUT      = 3'd4;

    // reset values
    localparam logic [7:0] RST_START_STOP_DELAY = 8'd7;
    localparam logic [7:0] RST_BIT_DELAY        = 8'd2;
    localparam logic [7:0] RST_ACK_HIGH_DELAY   = 8'd5;
    localparam logic [7:0] RST_SETTLE_DELAY     = 8'd1;
    localparam logic [7:0] RST_ACK_TIMEOUT      = 8'd250;
    localparam logic [5:0] RST_LINES            = 6'h3f;
    localparam logic [3:0] BITS_PER_BYTE        = 4'd8;

    typedef struct packed {
        logic [7:0] start_stop_delay;
        logic [7:0] bit_delay;
        logic [7:0] ack_high_delay;
        logic [7:0] settle_delay;
        logic [7:0] ack_timeout;
    } t_cfg;

    typedef struct packed {
        logic [2:0] func;
        logic       bus_select;
        logic [7:0] tx_byte;
        logic       send_ack;
        logic       sda0_in;
        logic       sda1_in;
    } t_item;

    typedef struct packed {
        logic [3:0] phase;
        logic       active_bus;
        logic [7:0] tick_count;
        logic [3:0] bit_index;
        logic [7:0] shift_reg;
        logic [7:0] poll_count;
        logic       ack_choice;
        logic [5:0] lines;
        logic [7:0] rx_hold;
    } t_state;

    typedef struct packed {
        logic [5:0] lines;
        logic       busy;
        logic       done;
        logic [7:0] rx_data;
        logic       ack_error;
        logic       rejected;
    } t_result;

endpackage

>>> hdl/ibm_step.sv
module ibm_step (
    input  ibm_pkg::t_state  i_state,
    input  ibm_pkg::t_cfg    i_cfg,
    input  ibm_pkg::t_item   i_item,
    output ibm_pkg::t_state  o_state,
    output ibm_pkg::t_result o_result
);

    // set one line of the chosen bus
    function automatic logic [5:0] f_line(input logic [5:0] lv, input logic bus,
                                          input logic [1:0] pos, input logic v);
        logic [2:0] idx;
        logic [5:0] r;
        idx = bus ? (3'(pos) + 3'd3) : 3'(pos);
        r = lv;
        r[idx] = v;
        return r;
    endfunction

    // a zero delay counts as one tick
    function automatic logic [7:0] f_dly(input logic [7:0] d);
        return (d == 8'd0) ? 8'd1 : d;
    endfunction

    ibm_pkg::t_state n;
    logic [5:0] lv;
    logic       bus;
    logic       sda;
    logic       done;
    logic       err;
    logic       rej;
    logic [3:0] bit_nx;

    // one tick of the sequencer
    always_comb begin
        n      = i_state;
        lv     = i_state.lines;
        bus    = i_state.active_bus;
        sda    = i_state.active_bus ? i_item.sda1_in : i_item.sda0_in;
        done   = 1'b0;
        err    = 1'b0;
        rej    = 1'b0;
        bit_nx = i_state.bit_index + 4'd1;
        if (i_state.phase == ibm_pkg::PH_IDLE) begin
            // command decode while idle
            case (i_item.func)
                ibm_pkg::FN_START: begin
                    bus = i_item.bus_select;
                    lv = f_line(lv, bus, ibm_pkg::POS_DRV, 1'b1);
                    lv = f_line(lv, bus, ibm_pkg::POS_SDA, 1'b1);
                    lv = f_line(lv, bus, ibm_pkg::POS_SCL, 1'b1);
                    n.phase = ibm_pkg::PH_ST_A;
                    n.tick_count = f_dly(i_cfg.start_stop_delay);
                end
                ibm_pkg::FN_STOP: begin
                    bus = i_item.bus_select;
                    n.ack_choice = 1'b0;
                    lv = f_line(lv, bus, ibm_pkg::POS_DRV, 1'b1);
                    lv = f_line(lv, bus, ibm_pkg::POS_SCL, 1'b0);
                    lv = f_line(lv, bus, ibm_pkg::POS_SDA, 1'b0);
                    n.phase = ibm_pkg::PH_SP_A;
                    n.tick_count = f_dly(i_cfg.start_stop_delay);
                end
                ibm_pkg::FN_WRITE: begin
                    bus = i_item.bus_select;
                    n.shift_reg = i_item.tx_byte;
                    n.bit_index = 4'd0;
                    lv = f_line(lv, bus, ibm_pkg::POS_DRV, 1'b1);
                    lv = f_line(lv, bus, ibm_pkg::POS_SCL, 1'b0);
                    n.phase = ibm_pkg::PH_W_BIT;
                    n.tick_count = f_dly(i_cfg.bit_delay);
                end
                ibm_pkg::FN_READ: begin
                    bus = i_item.bus_select;
                    n.ack_choice = i_item.send_ack;
                    n.shift_reg = 8'd0;
                    n.bit_index = 4'd0;
                    lv = f_line(lv, bus, ibm_pkg::POS_DRV, 1'b0);
                    lv = f_line(lv, bus, ibm_pkg::POS_SDA, 1'b1);
                    lv = f_line(lv, bus, ibm_pkg::POS_SCL, 1'b0);
                    n.phase = ibm_pkg::PH_R_HIGH;
                    n.tick_count = f_dly(i_cfg.bit_delay);
                end
                default: begin
                end
            endcase
        end else begin
            rej = (i_item.func != ibm_pkg::FN_NONE);
            if (i_state.tick_count > 8'd1) begin
                n.tick_count = i_state.tick_count - 8'd1;
            end else begin
                case (i_state.phase)
                    ibm_pkg::PH_ST_A: begin
                        lv = f_line(lv, bus, ibm_pkg::POS_SDA, 1'b0);
                        n.phase = ibm_pkg::PH_ST_B;
                        n.tick_count = f_dly(i_cfg.start_stop_delay);
                    end
                    ibm_pkg::PH_ST_B: begin
                        lv = f_line(lv, bus, ibm_pkg::POS_SCL, 1'b0);
                        n.phase = ibm_pkg::PH_IDLE;
                        done = 1'b1;
                    end
                    ibm_pkg::PH_SP_A: begin
                        lv = f_line(lv, bus, ibm_pkg::POS_SCL, 1'b1);
                        n.phase = ibm_pkg::PH_SP_B;
                        n.tick_count = f_dly(i_cfg.start_stop_delay);
                    end
                    ibm_pkg::PH_SP_B: begin
                        lv = f_line(lv, bus, ibm_pkg::POS_SDA, 1'b1);
                        n.phase = ibm_pkg::PH_SP_C;
                        n.tick_count = f_dly(i_cfg.start_stop_delay);
                    end
                    ibm_pkg::PH_SP_C: begin
                        n.phase = ibm_pkg::PH_IDLE;
                        done = 1'b1;
                        err = i_state.ack_choice;
                        n.ack_choice = 1'b0;
                    end
                    ibm_pkg::PH_W_BIT: begin
                        lv = f_line(lv, bus, ibm_pkg::POS_SDA, i_state.shift_reg[7]);
                        n.shift_reg = {i_state.shift_reg[6:0], 1'b0};
                        n.phase = ibm_pkg::PH_W_HIGH;
                        n.tick_count = f_dly(i_cfg.bit_delay);
                    end
                    ibm_pkg::PH_W_HIGH: begin
                        lv = f_line(lv, bus, ibm_pkg::POS_SCL, 1'b1);
                        n.phase = ibm_pkg::PH_W_LOW;
                        n.tick_count = f_dly(i_cfg.bit_delay);
                    end
                    ibm_pkg::PH_W_LOW: begin
                        lv = f_line(lv, bus, ibm_pkg::POS_SCL, 1'b0);
                        n.bit_index = bit_nx;
                        n.phase = (bit_nx < ibm_pkg::BITS_PER_BYTE) ? ibm_pkg::PH_W_BIT
                                                                    : ibm_pkg::PH_A_REL;
                        n.tick_count = f_dly(i_cfg.bit_delay);
                    end
                    ibm_pkg::PH_A_REL: begin
                        lv = f_line(lv, bus, ibm_pkg::POS_DRV, 1'b0);
                        lv = f_line(lv, bus, ibm_pkg::POS_SDA, 1'b1);
                        n.phase = ibm_pkg::PH_A_HIGH;
                        n.tick_count = f_dly(i_cfg.settle_delay);
                    end
                    ibm_pkg::PH_A_HIGH: begin
                        lv = f_line(lv, bus, ibm_pkg::POS_SCL, 1'b1);
                        n.poll_count = 8'd0;
                        n.phase = ibm_pkg::PH_A_POLL;
                        n.tick_count = f_dly(i_cfg.settle_delay);
                    end
                    ibm_pkg::PH_A_POLL: begin
                        // acknowledge poll, stop on timeout
                        if (!sda) begin
                            lv = f_line(lv, bus, ibm_pkg::POS_SCL, 1'b0);
                            n.phase = ibm_pkg::PH_IDLE;
                            done = 1'b1;
                        end else if (i_state.poll_count >= i_cfg.ack_timeout) begin
                            n.ack_choice = 1'b1;
                            lv = f_line(lv, bus, ibm_pkg::POS_DRV, 1'b1);
                            lv = f_line(lv, bus, ibm_pkg::POS_SCL, 1'b0);
                            lv = f_line(lv, bus, ibm_pkg::POS_SDA, 1'b0);
                            n.phase = ibm_pkg::PH_SP_A;
                            n.tick_count = f_dly(i_cfg.start_stop_delay);
                        end else begin
                            n.poll_count = i_state.poll_count + 8'd1;
                            n.tick_count = 8'd1;
                        end
                    end
                    ibm_pkg::PH_R_HIGH: begin
                        lv = f_line(lv, bus, ibm_pkg::POS_SCL, 1'b1);
                        n.shift_reg = {i_state.shift_reg[6:0], sda};
                        n.bit_index = bit_nx;
                        n.phase = ibm_pkg::PH_R_LOW;
                        n.tick_count = f_dly(i_cfg.settle_delay);
                    end
                    ibm_pkg::PH_R_LOW: begin
                        lv = f_line(lv, bus, ibm_pkg::POS_SCL, 1'b0);
                        if (i_state.bit_index < ibm_pkg::BITS_PER_BYTE) begin
                            n.phase = ibm_pkg::PH_R_HIGH;
                        end else begin
                            lv = f_line(lv, bus, ibm_pkg::POS_DRV, 1'b1);
                            lv = f_line(lv, bus, ibm_pkg::POS_SDA, !i_state.ack_choice);
                            n.phase = ibm_pkg::PH_RA_HIGH;
                        end
                        n.tick_count = f_dly(i_cfg.bit_delay);
                    end
                    ibm_pkg::PH_RA_HIGH: begin
                        lv = f_line(lv, bus, ibm_pkg::POS_SCL, 1'b1);
                        n.phase = ibm_pkg::PH_RA_END;
                        n.tick_count = f_dly(i_cfg.ack_high_delay);
                    end
                    ibm_pkg::PH_RA_END: begin
                        lv = f_line(lv, bus, ibm_pkg::POS_SCL, 1'b0);
                        n.rx_hold = i_state.shift_reg;
                        n.phase = ibm_pkg::PH_IDLE;
                        done = 1'b1;
                    end
                    default: begin
                        n.phase = ibm_pkg::PH_IDLE;
                    end
                endcase
            end
        end
        n.active_bus = bus;
        n.lines = lv;
    end

    // result of this tick
    assign o_state            = n;
    assign o_result.lines     = n.lines;
    assign o_result.busy      = (n.phase != ibm_pkg::PH_IDLE);
    assign o_result.done      = done;
    assign o_result.rx_data   = n.rx_hold;
    assign o_result.ack_error = err;
    assign o_result.rejected  = rej;

endmodule

>>> hdl/i2c_bitbang_master.sv
// Two-bus I2C master stepped by timing ticks: each input transfer is one tick
// and yields exactly one result transfer holding the line levels and status
// after that tick. A command (start, stop, write byte with acknowledge wait,
// read byte with master ACK/NACK) is taken only on a tick that finds the
// sequencer idle; a command on a busy tick is flagged rejected and ignored.
// One tick is accepted every clock cycle unless the result channel stalls;
// each tick goes through the input register, the combinational sequencer
// step and the result register before its result appears. Configuration
// writes are meant for idle periods only.
module i2c_bitbang_master (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // tick channel
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [2:0] i_func,
    input  logic       i_bus_select,
    input  logic [7:0] i_tx_byte,
    input  logic       i_send_ack,
    input  logic       i_sda0_in,
    input  logic       i_sda1_in,
    // result channel
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic       o_scl0,
    output logic       o_sda0_out,
    output logic       o_sda0_drive,
    output logic       o_scl1,
    output logic       o_sda1_out,
    output logic       o_sda1_drive,
    output logic       o_busy_res,
    output logic       o_done_res,
    output logic [7:0] o_rx_data,
    output logic       o_ack_error,
    output logic       o_rejected,
    // configuration channel
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [2:0] i_cfg_index,
    input  logic [7:0] i_cfg_data
);

    ibm_pkg::t_cfg    r_cfg;
    ibm_pkg::t_item   r_item;
    logic             r_in_valid;
    ibm_pkg::t_state  r_state;
    ibm_pkg::t_state  n_state;
    ibm_pkg::t_result n_result;
    ibm_pkg::t_result r_result;
    logic             r_out_valid;
    logic             w_step;

    // handshake control
    assign w_step      = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready  = !r_in_valid || w_step;
    assign o_cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.start_stop_delay <= ibm_pkg::RST_START_STOP_DELAY;
            r_cfg.bit_delay        <= ibm_pkg::RST_BIT_DELAY;
            r_cfg.ack_high_delay   <= ibm_pkg::RST_ACK_HIGH_DELAY;
            r_cfg.settle_delay     <= ibm_pkg::RST_SETTLE_DELAY;
            r_cfg.ack_timeout      <= ibm_pkg::RST_ACK_TIMEOUT;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                ibm_pkg::CFG_START_STOP_DELAY: r_cfg.start_stop_delay <= i_cfg_data;
                ibm_pkg::CFG_BIT_DELAY:        r_cfg.bit_delay        <= i_cfg_data;
                ibm_pkg::CFG_ACK_HIGH_DELAY:   r_cfg.ack_high_delay   <= i_cfg_data;
                ibm_pkg::CFG_SETTLE_DELAY:     r_cfg.settle_delay     <= i_cfg_data;
                ibm_pkg::CFG_ACK_TIMEOUT:      r_cfg.ack_timeout      <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_item.func       <= i_func;
            r_item.bus_select <= i_bus_select;
            r_item.tx_byte    <= i_tx_byte;
            r_item.send_ack   <= i_send_ack;
            r_item.sda0_in    <= i_sda0_in;
            r_item.sda1_in    <= i_sda1_in;
        end
    end

    ibm_step u_step (
        .i_state  (r_state),
        .i_cfg    (r_cfg),
        .i_item   (r_item),
        .o_state  (n_state),
        .o_result (n_result)
    );

    // sequencer state, advanced once per tick
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.phase      <= ibm_pkg::PH_IDLE;
            r_state.active_bus <= 1'b0;
            r_state.tick_count <= 8'd0;
            r_state.bit_index  <= 4'd0;
            r_state.shift_reg  <= 8'd0;
            r_state.poll_count <= 8'd0;
            r_state.ack_choice <= 1'b0;
            r_state.lines      <= ibm_pkg::RST_LINES;
            r_state.rx_hold    <= 8'd0;
        end else if (w_step) begin
            r_state <= n_state;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_step) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step) begin
            r_result <= n_result;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_scl0       = r_result.lines[0];
    assign o_sda0_out   = r_result.lines[1];
    assign o_sda0_drive = r_result.lines[2];
    assign o_scl1       = r_result.lines[3];
    assign o_sda1_out   = r_result.lines[4];
    assign o_sda1_drive = r_result.lines[5];
    assign o_busy_res   = r_result.busy;
    assign o_done_res   = r_result.done;
    assign o_rx_data    = r_result.rx_data;
    assign o_ack_error  = r_result.ack_error;
    assign o_rejected   = r_result.rejected;

`ifndef SYNTHESIS
    // a running phase always has a live tick count
    a_tick_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.phase != ibm_pkg::PH_IDLE |-> r_state.tick_count != 8'd0)
        else $error("tick count zero in active phase");

    // bit counter never passes one byte
    a_bit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.bit_index <= ibm_pkg::BITS_PER_BYTE)
        else $error("bit index out of range");

    // acknowledge error only comes with done, and done leaves the block idle
    a_err_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_result.ack_error |-> r_result.done && !r_result.busy)
        else $error("ack error without finished command");

    // state advances only together with a new result
    a_state_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_step |=> $stable(r_state))
        else $error("sequencer moved without a tick");
`endif

endmodule

>>> tb/sv/tb_i2c_bitbang_master.sv
module tb_i2c_bitbang_master;
    timeunit 1ns;
    timeprecision 1ps;

    // func codes outside the defined command set
    localparam logic [2:0] FN_UNK_LO = 3'd5;
    localparam logic [2:0] FN_UNK_HI = 3'd7;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_in_valid;
    logic       o_in_ready;
    logic [2:0] i_func;
    logic       i_bus_select;
    logic [7:0] i_tx_byte;
    logic       i_send_ack;
    logic       i_sda0_in;
    logic       i_sda1_in;
    logic       o_out_valid;
    logic       i_out_ready;
    logic       o_scl0;
    logic       o_sda0_out;
    logic       o_sda0_drive;
    logic       o_scl1;
    logic       o_sda1_out;
    logic       o_sda1_drive;
    logic       o_busy_res;
    logic       o_done_res;
    logic [7:0] o_rx_data;
    logic       o_ack_error;
    logic       o_rejected;
    logic       i_cfg_valid;
    logic       o_cfg_ready;
    logic [2:0] i_cfg_index;
    logic [7:0] i_cfg_data;

    i2c_bitbang_master uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_func       (i_func),
        .i_bus_select (i_bus_select),
        .i_tx_byte    (i_tx_byte),
        .i_send_ack   (i_send_ack),
        .i_sda0_in    (i_sda0_in),
        .i_sda1_in    (i_sda1_in),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_scl0       (o_scl0),
        .o_sda0_out   (o_sda0_out),
        .o_sda0_drive (o_sda0_drive),
        .o_scl1       (o_scl1),
        .o_sda1_out   (o_sda1_out),
        .o_sda1_drive (o_sda1_drive),
        .o_busy_res   (o_busy_res),
        .o_done_res   (o_done_res),
        .o_rx_data    (o_rx_data),
        .o_ack_error  (o_ack_error),
        .o_rejected   (o_rejected),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    // directed stimulus rows, typed rows carry an idle-line expectation
    typedef struct {
        logic [2:0] func;
        logic       bus;
        logic [7:0] tx;
        logic       sack;
        logic       sda0;
        logic       sda1;
        int         reps;
        bit         typed;
        logic       busy;
        logic       rej;
    } t_dir_row;

    typedef struct {
        ibm_pkg::t_cfg regs;
        int            ticks;
        int            send_idle;
        int            stall;
        int            hold;
    } t_phase_plan;

    localparam int DIR_ROWS = 23;
    localparam int PLAN_LEN = 9;

    t_dir_row dir_tab [DIR_ROWS] = '{
        '{ibm_pkg::FN_NONE,  1'b0, 8'h00, 1'b0, 1'b0, 1'b0,   1, 1'b1, 1'b0, 1'b0},
        '{FN_UNK_HI,         1'b1, 8'hff, 1'b1, 1'b1, 1'b1,   1, 1'b1, 1'b0, 1'b0},
        '{FN_UNK_LO,         1'b0, 8'h00, 1'b0, 1'b0, 1'b0,   1, 1'b1, 1'b0, 1'b0},
        '{ibm_pkg::FN_START, 1'b0, 8'h00, 1'b0, 1'b1, 1'b1,   1, 1'b1, 1'b1, 1'b0},
        '{ibm_pkg::FN_WRITE, 1'b1, 8'hff, 1'b1, 1'b1, 1'b1,   1, 1'b1, 1'b1, 1'b1},
        '{ibm_pkg::FN_NONE,  1'b0, 8'h00, 1'b0, 1'b1, 1'b1,  16, 1'b0, 1'b0, 1'b0},
        '{ibm_pkg::FN_WRITE, 1'b0, 8'h00, 1'b0, 1'b1, 1'b1,   1, 1'b0, 1'b0, 1'b0},
        '{ibm_pkg::FN_NONE,  1'b0, 8'h00, 1'b0, 1'b0, 1'b1,  60, 1'b0, 1'b0, 1'b0},
        '{ibm_pkg::FN_WRITE, 1'b1, 8'hff, 1'b0, 1'b1, 1'b1,   1, 1'b0, 1'b0, 1'b0},
        '{ibm_pkg::FN_NONE,  1'b0, 8'h00, 1'b0, 1'b0, 1'b0,  60, 1'b0, 1'b0, 1'b0},
        '{ibm_pkg::FN_READ,  1'b0, 8'h00, 1'b1, 1'b1, 1'b1,   1, 1'b0, 1'b0, 1'b0},
        '{ibm_pkg::FN_NONE,  1'b0, 8'h00, 1'b0, 1'b1, 1'b1,  40, 1'b0, 1'b0, 1'b0},
        '{ibm_pkg::FN_READ,  1'b1, 8'h00, 1'b0, 1'b1, 1'b0,   1, 1'b0, 1'b0, 1'b0},
        '{ibm_pkg::FN_NONE,  1'b0, 8'h00, 1'b0, 1'b1, 1'b0,  40, 1'b0, 1'b0, 1'b0},
        '{ibm_pkg::FN_WRITE, 1'b1, 8'h5a, 1'b0, 1'b1, 1'b1,   1, 1'b0, 1'b0, 1'b0},
        '{ibm_pkg::FN_NONE,  1'b0, 8'h00, 1'b0, 1'b1, 1'b1, 340, 1'b0, 1'b0, 1'b0},
        '{ibm_pkg::FN_STOP,  1'b0, 8'h00, 1'b0, 1'b1, 1'b1,   1, 1'b0, 1'b0, 1'b0},
        '{ibm_pkg::FN_STOP,  1'b1, 8'h00, 1'b0, 1'b1, 1'b1,   1, 1'b0, 1'b0, 1'b0},
        '{ibm_pkg::FN_NONE,  1'b0, 8'h00, 1'b0, 1'b1, 1'b1,  24, 1'b0, 1'b0, 1'b0},
        '{ibm_pkg::FN_START, 1'b1, 8'h00, 1'b0, 1'b1, 1'b1,   1, 1'b0, 1'b0, 1'b0},
        '{ibm_pkg::FN_NONE,  1'b0, 8'h00, 1'b0, 1'b1, 1'b1,  16, 1'b0, 1'b0, 1'b0},
        '{ibm_pkg::FN_STOP,  1'b1, 8'h00, 1'b0, 1'b1, 1'b1,   1, 1'b0, 1'b0, 1'b0},
        '{ibm_pkg::FN_NONE,  1'b0, 8'h00, 1'b0, 1'b1, 1'b1,  24, 1'b0, 1'b0, 1'b0}
    };

    t_phase_plan run_plan [PLAN_LEN];

    // model of the sequencer
    ibm_pkg::t_cfg cur_cfg;
    logic [3:0]    seq_phase;
    logic          cur_bus;
    logic [7:0]    wait_cnt;
    logic [3:0]    bit_cnt;
    logic [7:0]    shifter;
    logic [7:0]    poll_cnt;
    logic          ack_flag;
    logic [5:0]    line_lvl;
    logic [7:0]    rx_byte;

    ibm_pkg::t_result bus_state_q [$];
    int               err_cnt = 0;
    int               send_idle_pct = 0;
    int               stall_pct = 0;
    int               hold_req = 0;
    int               hold_left = 0;
    int               slave_ack_pct = 60;

    // clock
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // run limit
    initial begin
        #2000000;
        $display("i2c_bitbang_master regression: fail");
        $finish;
    end

    function automatic void drive_line(logic [1:0] pos, logic v);
        line_lvl[int'(cur_bus) * 3 + int'(pos)] = v;
    endfunction

    // a zero delay counts as one tick
    function automatic void arm(logic [3:0] nxt, logic [7:0] d);
        seq_phase = nxt;
        wait_cnt = (d == 8'd0) ? 8'd1 : d;
    endfunction

    function automatic void open_stop();
        drive_line(ibm_pkg::POS_DRV, 1'b1);
        drive_line(ibm_pkg::POS_SCL, 1'b0);
        drive_line(ibm_pkg::POS_SDA, 1'b0);
        arm(ibm_pkg::PH_SP_A, cur_cfg.start_stop_delay);
    endfunction

    // one tick of the bus sequencer, returns line levels and status after it
    function automatic ibm_pkg::t_result advance_bus(ibm_pkg::t_item it);
        ibm_pkg::t_result r;
        logic             sda;
        logic             done;
        logic             err;
        logic             rej;
        done = 1'b0;
        err = 1'b0;
        rej = 1'b0;
        sda = cur_bus ? it.sda1_in : it.sda0_in;
        if (seq_phase == ibm_pkg::PH_IDLE) begin
            case (it.func)
                ibm_pkg::FN_START: begin
                    cur_bus = it.bus_select;
                    drive_line(ibm_pkg::POS_DRV, 1'b1);
                    drive_line(ibm_pkg::POS_SDA, 1'b1);
                    drive_line(ibm_pkg::POS_SCL, 1'b1);
                    arm(ibm_pkg::PH_ST_A, cur_cfg.start_stop_delay);
                end
                ibm_pkg::FN_STOP: begin
                    cur_bus = it.bus_select;
                    ack_flag = 1'b0;
                    open_stop();
                end
                ibm_pkg::FN_WRITE: begin
                    cur_bus = it.bus_select;
                    shifter = it.tx_byte;
                    bit_cnt = 4'd0;
                    drive_line(ibm_pkg::POS_DRV, 1'b1);
                    drive_line(ibm_pkg::POS_SCL, 1'b0);
                    arm(ibm_pkg::PH_W_BIT, cur_cfg.bit_delay);
                end
                ibm_pkg::FN_READ: begin
                    cur_bus = it.bus_select;
                    ack_flag = it.send_ack;
                    shifter = 8'd0;
                    bit_cnt = 4'd0;
                    drive_line(ibm_pkg::POS_DRV, 1'b0);
                    drive_line(ibm_pkg::POS_SDA, 1'b1);
                    drive_line(ibm_pkg::POS_SCL, 1'b0);
                    arm(ibm_pkg::PH_R_HIGH, cur_cfg.bit_delay);
                end
                default: ;
            endcase
        end else begin
            // commands on a busy tick are dropped
            rej = (it.func != ibm_pkg::FN_NONE);
            if (wait_cnt > 8'd1) begin
                wait_cnt = wait_cnt - 8'd1;
            end else begin
                case (seq_phase)
                    ibm_pkg::PH_ST_A: begin
                        drive_line(ibm_pkg::POS_SDA, 1'b0);
                        arm(ibm_pkg::PH_ST_B, cur_cfg.start_stop_delay);
                    end
                    ibm_pkg::PH_ST_B: begin
                        drive_line(ibm_pkg::POS_SCL, 1'b0);
                        seq_phase = ibm_pkg::PH_IDLE;
                        done = 1'b1;
                    end
                    ibm_pkg::PH_SP_A: begin
                        drive_line(ibm_pkg::POS_SCL, 1'b1);
                        arm(ibm_pkg::PH_SP_B, cur_cfg.start_stop_delay);
                    end
                    ibm_pkg::PH_SP_B: begin
                        drive_line(ibm_pkg::POS_SDA, 1'b1);
                        arm(ibm_pkg::PH_SP_C, cur_cfg.start_stop_delay);
                    end
                    ibm_pkg::PH_SP_C: begin
                        seq_phase = ibm_pkg::PH_IDLE;
                        done = 1'b1;
                        err = ack_flag;
                        ack_flag = 1'b0;
                    end
                    ibm_pkg::PH_W_BIT: begin
                        drive_line(ibm_pkg::POS_SDA, shifter[7]);
                        shifter = {shifter[6:0], 1'b0};
                        arm(ibm_pkg::PH_W_HIGH, cur_cfg.bit_delay);
                    end
                    ibm_pkg::PH_W_HIGH: begin
                        drive_line(ibm_pkg::POS_SCL, 1'b1);
                        arm(ibm_pkg::PH_W_LOW, cur_cfg.bit_delay);
                    end
                    ibm_pkg::PH_W_LOW: begin
                        drive_line(ibm_pkg::POS_SCL, 1'b0);
                        bit_cnt = bit_cnt + 4'd1;
                        arm((bit_cnt < ibm_pkg::BITS_PER_BYTE) ? ibm_pkg::PH_W_BIT
                                                               : ibm_pkg::PH_A_REL,
                            cur_cfg.bit_delay);
                    end
                    ibm_pkg::PH_A_REL: begin
                        drive_line(ibm_pkg::POS_DRV, 1'b0);
                        drive_line(ibm_pkg::POS_SDA, 1'b1);
                        arm(ibm_pkg::PH_A_HIGH, cur_cfg.settle_delay);
                    end
                    ibm_pkg::PH_A_HIGH: begin
                        drive_line(ibm_pkg::POS_SCL, 1'b1);
                        poll_cnt = 8'd0;
                        arm(ibm_pkg::PH_A_POLL, cur_cfg.settle_delay);
                    end
                    ibm_pkg::PH_A_POLL: begin
                        // low sda is the acknowledge, too many high polls abort
                        if (!sda) begin
                            drive_line(ibm_pkg::POS_SCL, 1'b0);
                            seq_phase = ibm_pkg::PH_IDLE;
                            done = 1'b1;
                        end else if (poll_cnt >= cur_cfg.ack_timeout) begin
                            ack_flag = 1'b1;
                            open_stop();
                        end else begin
                            poll_cnt = poll_cnt + 8'd1;
                            wait_cnt = 8'd1;
                        end
                    end
                    ibm_pkg::PH_R_HIGH: begin
                        drive_line(ibm_pkg::POS_SCL, 1'b1);
                        shifter = {shifter[6:0], sda};
                        bit_cnt = bit_cnt + 4'd1;
                        arm(ibm_pkg::PH_R_LOW, cur_cfg.settle_delay);
                    end
                    ibm_pkg::PH_R_LOW: begin
                        drive_line(ibm_pkg::POS_SCL, 1'b0);
                        if (bit_cnt < ibm_pkg::BITS_PER_BYTE) begin
                            arm(ibm_pkg::PH_R_HIGH, cur_cfg.bit_delay);
                        end else begin
                            drive_line(ibm_pkg::POS_DRV, 1'b1);
                            drive_line(ibm_pkg::POS_SDA, ~ack_flag);
                            arm(ibm_pkg::PH_RA_HIGH, cur_cfg.bit_delay);
                        end
                    end
                    ibm_pkg::PH_RA_HIGH: begin
                        drive_line(ibm_pkg::POS_SCL, 1'b1);
                        arm(ibm_pkg::PH_RA_END, cur_cfg.ack_high_delay);
                    end
                    ibm_pkg::PH_RA_END: begin
                        drive_line(ibm_pkg::POS_SCL, 1'b0);
                        rx_byte = shifter;
                        seq_phase = ibm_pkg::PH_IDLE;
                        done = 1'b1;
                    end
                    default: seq_phase = ibm_pkg::PH_IDLE;
                endcase
            end
        end
        r.lines = line_lvl;
        r.busy = (seq_phase != ibm_pkg::PH_IDLE);
        r.done = done;
        r.rx_data = rx_byte;
        r.ack_error = err;
        r.rejected = rej;
        return r;
    endfunction

    // random tick: commands when idle, mostly plain ticks while busy,
    // and a slave that acknowledges with some probability
    function automatic ibm_pkg::t_item make_tick(bit drain_only);
        ibm_pkg::t_item it;
        int             pick;
        it.func = ibm_pkg::FN_NONE;
        it.bus_select = 1'($urandom_range(1));
        it.tx_byte = 8'($urandom_range(255));
        it.send_ack = 1'($urandom_range(1));
        it.sda0_in = 1'($urandom_range(1));
        it.sda1_in = 1'($urandom_range(1));
        if (seq_phase == ibm_pkg::PH_IDLE) begin
            pick = $urandom_range(99);
            if (pick < 15) it.func = ibm_pkg::FN_NONE;
            else if (pick < 20) it.func = 3'($urandom_range(5, 7));
            else if (pick < 40) it.func = ibm_pkg::FN_START;
            else if (pick < 60) it.func = ibm_pkg::FN_STOP;
            else if (pick < 85) it.func = ibm_pkg::FN_WRITE;
            else it.func = ibm_pkg::FN_READ;
            if (it.func == ibm_pkg::FN_WRITE) begin
                pick = $urandom_range(99);
                slave_ack_pct = (pick < 60) ? 60 : (pick < 85) ? 10 : 0;
            end
        end else begin
            if (!drain_only && $urandom_range(99) < 8)
                it.func = 3'($urandom_range(1, 7));
            if (seq_phase inside {ibm_pkg::PH_A_REL, ibm_pkg::PH_A_HIGH,
                                  ibm_pkg::PH_A_POLL}) begin
                if (cur_bus) it.sda1_in = ($urandom_range(99) >= slave_ack_pct);
                else it.sda0_in = ($urandom_range(99) >= slave_ack_pct);
            end
        end
        return it;
    endfunction

    // offer one tick, called and returning at a falling edge
    task automatic send_tick(ibm_pkg::t_item it, bit typed, ibm_pkg::t_result typed_exp);
        ibm_pkg::t_result r;
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_func <= it.func;
        i_bus_select <= it.bus_select;
        i_tx_byte <= it.tx_byte;
        i_send_ack <= it.send_ack;
        i_sda0_in <= it.sda0_in;
        i_sda1_in <= it.sda1_in;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        r = advance_bus(it);
        bus_state_q.push_back(typed ? typed_exp : r);
        @(negedge i_clk);
    endtask

    // register write transfer, valid is left high for the caller to lower
    task automatic put_reg(logic [2:0] idx, logic [7:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            ibm_pkg::CFG_START_STOP_DELAY: cur_cfg.start_stop_delay = data;
            ibm_pkg::CFG_BIT_DELAY:        cur_cfg.bit_delay = data;
            ibm_pkg::CFG_ACK_HIGH_DELAY:   cur_cfg.ack_high_delay = data;
            ibm_pkg::CFG_SETTLE_DELAY:     cur_cfg.settle_delay = data;
            ibm_pkg::CFG_ACK_TIMEOUT:      cur_cfg.ack_timeout = data;
            default: ;
        endcase
        @(negedge i_clk);
    endtask

    // finish any command in flight and wait for every result
    task automatic settle();
        while (seq_phase != ibm_pkg::PH_IDLE) send_tick(make_tick(1'b1), 1'b0, '0);
        i_in_valid <= 1'b0;
        while (bus_state_q.size() != 0) @(negedge i_clk);
    endtask

    task automatic cmp_field(string name, logic [7:0] want, logic [7:0] got);
        if (want !== got) begin
            $error("%s: expected %0h, actual %0h", name, want, got);
            err_cnt++;
        end
    endtask

    // result ready with random stalls and a long hold on request
    initial begin
        i_out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req != 0) begin
                hold_left = hold_req;
                hold_req = 0;
            end
            if (hold_left != 0) begin
                i_out_ready <= 1'b0;
                hold_left--;
            end else begin
                i_out_ready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    // compare each result transfer with the oldest expected bus state
    always @(posedge i_clk) begin : result_check
        ibm_pkg::t_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (bus_state_q.size() == 0) begin
                $error("result transfer with no expected bus state");
                err_cnt++;
            end else begin
                want = bus_state_q.pop_front();
                cmp_field("scl0", 8'(want.lines[0]), 8'(o_scl0));
                cmp_field("sda0_out", 8'(want.lines[1]), 8'(o_sda0_out));
                cmp_field("sda0_drive", 8'(want.lines[2]), 8'(o_sda0_drive));
                cmp_field("scl1", 8'(want.lines[3]), 8'(o_scl1));
                cmp_field("sda1_out", 8'(want.lines[4]), 8'(o_sda1_out));
                cmp_field("sda1_drive", 8'(want.lines[5]), 8'(o_sda1_drive));
                cmp_field("busy_res", 8'(want.busy), 8'(o_busy_res));
                cmp_field("done_res", 8'(want.done), 8'(o_done_res));
                cmp_field("rx_data", want.rx_data, o_rx_data);
                cmp_field("ack_error", 8'(want.ack_error), 8'(o_ack_error));
                cmp_field("rejected", 8'(want.rejected), 8'(o_rejected));
            end
        end
    end

    initial begin : stimulus
        ibm_pkg::t_item   it;
        ibm_pkg::t_result typed_r;
        int               i;
        int               k;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_func = ibm_pkg::FN_NONE;
        i_bus_select = 1'b0;
        i_tx_byte = 8'h00;
        i_send_ack = 1'b0;
        i_sda0_in = 1'b1;
        i_sda1_in = 1'b1;
        i_cfg_valid = 1'b0;
        i_cfg_index = ibm_pkg::CFG_START_STOP_DELAY;
        i_cfg_data = 8'h00;

        cur_cfg.start_stop_delay = ibm_pkg::RST_START_STOP_DELAY;
        cur_cfg.bit_delay = ibm_pkg::RST_BIT_DELAY;
        cur_cfg.ack_high_delay = ibm_pkg::RST_ACK_HIGH_DELAY;
        cur_cfg.settle_delay = ibm_pkg::RST_SETTLE_DELAY;
        cur_cfg.ack_timeout = ibm_pkg::RST_ACK_TIMEOUT;
        seq_phase = ibm_pkg::PH_IDLE;
        cur_bus = 1'b0;
        wait_cnt = 8'd0;
        bit_cnt = 4'd0;
        shifter = 8'd0;
        poll_cnt = 8'd0;
        ack_flag = 1'b0;
        line_lvl = ibm_pkg::RST_LINES;
        rx_byte = 8'd0;

        // settings: extremes, zero delays, small values and random ones
        run_plan[0] = '{{8'd1, 8'd1, 8'd1, 8'd1, 8'd0}, 80, 0, 0, 0};
        run_plan[1] = '{{8'd0, 8'd0, 8'd0, 8'd0, 8'd2}, 80, 69, 0, 0};
        run_plan[2] = '{{8'd3, 8'd2, 8'd4, 8'd2, 8'd5}, 80, 0, 69, 0};
        run_plan[3] = '{{8'd2, 8'd1, 8'd3, 8'd1, 8'd1}, 80, 16, 16, 0};
        run_plan[4] = '{{8'd255, 8'd1, 8'd255, 8'd1, 8'd1}, 20, 0, 0, 0};
        run_plan[5] = '{{8'd1, 8'd2, 8'd1, 8'd1, 8'd8}, 100, 0, 16, 300};
        for (i = 6; i < PLAN_LEN; i++) begin
            run_plan[i].regs = {8'($urandom_range(1, 6)), 8'($urandom_range(1, 4)),
                                8'($urandom_range(1, 6)), 8'($urandom_range(1, 3)),
                                8'($urandom_range(0, 40))};
            run_plan[i].ticks = 60;
            run_plan[i].send_idle = (i == 6) ? 69 : (i == 8) ? 16 : 0;
            run_plan[i].stall = (i == 7) ? 69 : (i == 8) ? 16 : 0;
            run_plan[i].hold = 0;
        end

        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed part under the reset settings
        for (i = 0; i < DIR_ROWS; i++) begin
            it.func = dir_tab[i].func;
            it.bus_select = dir_tab[i].bus;
            it.tx_byte = dir_tab[i].tx;
            it.send_ack = dir_tab[i].sack;
            it.sda0_in = dir_tab[i].sda0;
            it.sda1_in = dir_tab[i].sda1;
            typed_r = '{lines: ibm_pkg::RST_LINES, busy: dir_tab[i].busy, done: 1'b0,
                        rx_data: 8'h00, ack_error: 1'b0, rejected: dir_tab[i].rej};
            for (k = 0; k < dir_tab[i].reps; k++)
                send_tick(it, dir_tab[i].typed, typed_r);
        end
        settle();

        // random phases, registers rewritten only while idle
        for (i = 0; i < PLAN_LEN; i++) begin
            put_reg(ibm_pkg::CFG_START_STOP_DELAY, run_plan[i].regs.start_stop_delay);
            put_reg(ibm_pkg::CFG_BIT_DELAY, run_plan[i].regs.bit_delay);
            put_reg(ibm_pkg::CFG_ACK_HIGH_DELAY, run_plan[i].regs.ack_high_delay);
            put_reg(ibm_pkg::CFG_SETTLE_DELAY, run_plan[i].regs.settle_delay);
            put_reg(ibm_pkg::CFG_ACK_TIMEOUT, run_plan[i].regs.ack_timeout);
            i_cfg_valid <= 1'b0;
            send_idle_pct = run_plan[i].send_idle;
            stall_pct = run_plan[i].stall;
            if (run_plan[i].hold != 0) begin
                @(posedge i_clk);
                hold_req = run_plan[i].hold;
                @(negedge i_clk);
            end
            for (k = 0; k < run_plan[i].ticks; k++)
                send_tick(make_tick(1'b0), 1'b0, '0);
            settle();
        end

        repeat (8) @(posedge i_clk);
        if (err_cnt == 0) begin
            $display("i2c_bitbang_master regression: pass");
        end else begin
            $display("i2c_bitbang_master regression: fail");
        end
        $finish;
    end

endmodule
